### rtl/core/axis_move_sequencer_defines.svh
// Assertion macros used by the move sequencer checker.
`ifndef AXIS_MOVE_SEQUENCER_DEFINES_SVH
`define AXIS_MOVE_SEQUENCER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("move sequencer check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define AMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("move sequencer check failed");

`endif

### rtl/core/amseq_pkg.sv
// Types, constants and field positions of the move sequencer.
package amseq_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int BUS_W       = 8;
  localparam int FLAGS_W     = 4;
  localparam int PHASE_W     = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Result word bit positions.
  localparam int OUT_LDDIR_BIT = 0;
  localparam int OUT_PHASE_LO  = 8;

  // Phase codes as they appear in the result word.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_INST  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RECAL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DIST  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DIR   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_MOVE  = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INST  = 6'b000010,
    S_RECAL = 6'b000100,
    S_DIST  = 6'b001000,
    S_DIR   = 6'b010000,
    S_MOVE  = 6'b100000
  } seq_state_t;

  // Counter commands from the controller.
  typedef struct packed {
    logic ld_dist;
    logic dec;
  } cnt_ctl_t;

  function automatic logic [PHASE_W-1:0] phase_code(input seq_state_t s);
    logic [PHASE_W-1:0] code;
    unique case (s)
      S_IDLE:  code = PH_IDLE;
      S_INST:  code = PH_INST;
      S_RECAL: code = PH_RECAL;
      S_DIST:  code = PH_DIST;
      S_DIR:   code = PH_DIR;
      S_MOVE:  code = PH_MOVE;
      default: code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/amseq_counter.sv
// Distance down counter with registered done flag.
module amseq_counter
  import amseq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  cnt_ctl_t         ctl,
  input  logic [BUS_W-1:0] load_value,
  output logic             done_r,
  output logic             done_nxt,
  output logic             lsb_nxt
);

  logic [COUNT_WIDTH-1:0]       count_r;
  logic [COUNT_WIDTH-1:0]       count_nxt;
  logic [COUNT_WIDTH+BUS_W-1:0] load_ext;

  // Zero-extend, then keep the counter's width.
  assign load_ext = {{COUNT_WIDTH{1'b0}}, load_value};

  always_comb begin
    priority if (ctl.ld_dist) begin
      count_nxt = load_ext[COUNT_WIDTH-1:0];
    end else if (ctl.dec) begin
      count_nxt = count_r - COUNT_WIDTH'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign done_nxt = (count_nxt == '0);
  assign lsb_nxt  = count_nxt[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b1;
    end else if (fire) begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

### rtl/core/amseq_ctrl.sv
// Sequencer state machine, instruction register and ready flag.
module amseq_ctrl
  import amseq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [BUS_W-1:0]   bus_value,
  input  logic               zero_switch,
  input  logic               clear_ready,
  input  logic               restart,
  input  logic               done_r,
  output cnt_ctl_t           cnt_ctl,
  output logic               load_direction,
  output logic               ready_nxt,
  output logic [FLAGS_W-1:0] flags_nxt,
  output logic [PHASE_W-1:0] phase_nxt
);

  seq_state_t         state_r;
  seq_state_t         state_nxt;
  logic [FLAGS_W-1:0] flags_r;
  logic               ready_r;
  logic               ld_inst;
  logic               set_rdy;

  always_comb begin
    state_nxt      = state_r;
    cnt_ctl        = '0;
    ld_inst        = 1'b0;
    set_rdy        = 1'b0;
    load_direction = 1'b0;
    if (restart) begin
      state_nxt = S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!ready_r) begin
            ld_inst   = 1'b1;
            state_nxt = S_INST;
          end
        end
        S_INST: begin
          priority if (flags_r[1]) begin
            set_rdy   = 1'b1;
            state_nxt = S_IDLE;
          end else if (flags_r[0]) begin
            load_direction = 1'b1;
            state_nxt      = S_RECAL;
          end else begin
            set_rdy   = 1'b1;
            state_nxt = S_DIST;
          end
        end
        S_RECAL: begin
          if (zero_switch) begin
            set_rdy   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_ctl.dec = 1'b1;
          end
        end
        S_DIST: begin
          if (!ready_r) begin
            cnt_ctl.ld_dist = 1'b1;
            state_nxt       = S_DIR;
          end
        end
        S_DIR: begin
          load_direction = 1'b1;
          state_nxt      = S_MOVE;
        end
        S_MOVE: begin
          if (done_r) begin
            set_rdy   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_ctl.dec = 1'b1;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // Clear wins over set.
  always_comb begin
    priority if (clear_ready) begin
      ready_nxt = 1'b0;
    end else if (set_rdy) begin
      ready_nxt = 1'b1;
    end else begin
      ready_nxt = ready_r;
    end
  end

  assign flags_nxt = ld_inst ? bus_value[FLAGS_W-1:0] : flags_r;
  assign phase_nxt = phase_code(state_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flags_r <= '0;
      ready_r <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
      flags_r <= flags_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

### rtl/core/amseq_out_buf.sv
// Output register with a skid stage for the result word.
module amseq_out_buf
  import amseq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [OUT_TDATA_W-1:0] push_data,
  output logic                   can_push,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   skid_valid_r;
  logic [OUT_TDATA_W-1:0] skid_data_r;
  logic                   out_free;

  assign can_push   = !skid_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // Refill from the skid stage first; push is blocked while it is full.
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (!out_free && push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

### rtl/core/axis_move_sequencer.sv
// Move sequencer top level: input unpack, controller, counter, output buffer.
// A word's result is registered at the edge that accepts it, in the output register or, on a stall, the skid word.
// Throughput: one word per cycle while in_tready is high; the state machine advances once per accepted word.
// A stalled output is absorbed by one skid word, so in_tready drops only when both are full.
// Reset (rst_n low, synchronous): state idle, count 0, done 1, flags 0, ready 0, buffer empty.
module axis_move_sequencer
  import amseq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] bus_value, [8] zero_switch, [9] clear_ready, [10] restart, [15:11] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] load_direction, [1] ready_flag, [2] count_done, [3] count_lsb,
  // [4] reposition, [5] magnet_on, [6] xy_select, [7] reverse_dir,
  // [10:8] phase, [15:11] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic               fire;
  logic [BUS_W-1:0]   bus_value;
  logic               zero_switch;
  logic               clear_ready;
  logic               restart;
  cnt_ctl_t           cnt_ctl;
  logic               done_r;
  logic               done_nxt;
  logic               lsb_nxt;
  logic               load_direction;
  logic               ready_nxt;
  logic [FLAGS_W-1:0] flags_nxt;
  logic [PHASE_W-1:0] phase_nxt;
  logic [OUT_TDATA_W-1:0] result;

  // Every state update happens only on an accepted word, one tick per word.
  assign fire = in_tvalid && in_tready;

  assign bus_value   = in_tdata[BUS_W-1:0];
  assign zero_switch = in_tdata[BUS_W];
  assign clear_ready = in_tdata[BUS_W+1];
  assign restart     = in_tdata[BUS_W+2];

  amseq_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .bus_value      (bus_value),
    .zero_switch    (zero_switch),
    .clear_ready    (clear_ready),
    .restart        (restart),
    .done_r         (done_r),
    .cnt_ctl        (cnt_ctl),
    .load_direction (load_direction),
    .ready_nxt      (ready_nxt),
    .flags_nxt      (flags_nxt),
    .phase_nxt      (phase_nxt)
  );

  amseq_counter u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .ctl        (cnt_ctl),
    .load_value (bus_value),
    .done_r     (done_r),
    .done_nxt   (done_nxt),
    .lsb_nxt    (lsb_nxt)
  );

  // Report values after the tick, except the direction strobe of this tick.
  assign result = {5'b0, phase_nxt, flags_nxt, lsb_nxt, done_nxt, ready_nxt, load_direction};

  amseq_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (result),
    .can_push   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/amseq_checker.sv
// Port-level checks of the move sequencer and their bind.
`include "axis_move_sequencer_defines.svh"

module amseq_checker
  import amseq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic               stall;
  logic               strobe;
  logic [PHASE_W-1:0] phase;

  assign stall  = out_tvalid && !out_tready;
  assign strobe = out_tvalid && out_tdata[OUT_LDDIR_BIT];
  assign phase  = out_tdata[OUT_PHASE_LO+PHASE_W-1:OUT_PHASE_LO];

  `AMS_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, stall, out_tvalid)
  `AMS_ASSERT_NEXT(a_out_data_holds, clk, rst_n, stall, $stable(out_tdata))
  `AMS_ASSERT_IMP(a_strobe_phase, clk, rst_n, strobe, (phase == PH_RECAL) || (phase == PH_MOVE))
  `AMS_ASSERT_IMP(a_done_even, clk, rst_n, out_tvalid && out_tdata[2], !out_tdata[3])

endmodule

bind axis_move_sequencer amseq_checker u_amseq_checker (.*);

### bench/move_seq_checker.sv
// Checker for the move sequencer: predicts each result word and compares it.
`timescale 1ns / 1ps

module move_seq_checker
  import amseq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned            errors,
  output int unsigned            pending
);

  // Result word fields, lowest bit last.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               reverse_dir;
    logic               xy_select;
    logic               magnet_on;
    logic               reposition;
    logic               count_lsb;
    logic               count_done;
    logic               ready_flag;
    logic               load_direction;
  } status_t;

  localparam int STATUS_W = $bits(status_t);

  logic [PHASE_W-1:0]     phase_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic                   done_q;
  logic [FLAGS_W-1:0]     flags_q;
  logic                   ready_q;
  status_t                status_q[$];

  task automatic clear_sequencer();
    phase_q = PH_IDLE;
    count_q = '0;
    done_q  = 1'b1;
    flags_q = '0;
    ready_q = 1'b0;
  endtask

  // Advance the sequencer by one tick and return the status after it.
  task automatic tick_sequencer(input logic [BUS_W-1:0] bus, input logic zero_sw,
                                input logic clr_rdy, input logic restart,
                                output status_t st);
    logic               ld_dist, dec, ld_inst, set_rdy, ld_dir;
    logic [PHASE_W-1:0] nxt;
    ld_dist = 1'b0;
    dec     = 1'b0;
    ld_inst = 1'b0;
    set_rdy = 1'b0;
    ld_dir  = 1'b0;
    nxt     = phase_q;
    if (restart) begin
      nxt = PH_IDLE;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (!ready_q) begin
            ld_inst = 1'b1;
            nxt = PH_INST;
          end
        end
        PH_INST: begin
          if (flags_q[1]) begin
            set_rdy = 1'b1;
            nxt = PH_IDLE;
          end else if (flags_q[0]) begin
            ld_dir = 1'b1;
            nxt = PH_RECAL;
          end else begin
            set_rdy = 1'b1;
            nxt = PH_DIST;
          end
        end
        PH_RECAL: begin
          if (zero_sw) begin
            set_rdy = 1'b1;
            nxt = PH_IDLE;
          end else begin
            dec = 1'b1;
          end
        end
        PH_DIST: begin
          if (!ready_q) begin
            ld_dist = 1'b1;
            nxt = PH_DIR;
          end
        end
        PH_DIR: begin
          ld_dir = 1'b1;
          nxt = PH_MOVE;
        end
        PH_MOVE: begin
          if (done_q) begin
            set_rdy = 1'b1;
            nxt = PH_IDLE;
          end else begin
            dec = 1'b1;
          end
        end
        default: nxt = PH_IDLE;
      endcase
    end

    if (ld_dist) count_q = COUNT_WIDTH'(bus);
    else if (dec) count_q = count_q - 1'b1;
    done_q = (count_q == '0);
    if (ld_inst) flags_q = bus[FLAGS_W-1:0];
    if (clr_rdy) ready_q = 1'b0;
    else if (set_rdy) ready_q = 1'b1;
    phase_q = nxt;

    st.load_direction = ld_dir;
    st.ready_flag     = ready_q;
    st.count_done     = done_q;
    st.count_lsb      = count_q[0];
    st.reposition     = flags_q[0];
    st.magnet_on      = flags_q[1];
    st.xy_select      = flags_q[2];
    st.reverse_dir    = flags_q[3];
    st.phase          = phase_q;
  endtask

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    status_t got;
    status_t nxt_st;
    if (!rst_n) begin
      clear_sequencer();
      status_q.delete();
      errors = 0;
    end else begin
      // Check the result before queueing this edge's prediction.
      if (out_tvalid && out_tready) begin
        got = status_t'(out_tdata[STATUS_W-1:0]);
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got 0x%04h", $time, out_tdata);
        end else begin
          want = status_q.pop_front();
          check_field("load_direction", want.load_direction, got.load_direction);
          check_field("ready_flag", want.ready_flag, got.ready_flag);
          check_field("count_done", want.count_done, got.count_done);
          check_field("count_lsb", want.count_lsb, got.count_lsb);
          check_field("reposition", want.reposition, got.reposition);
          check_field("magnet_on", want.magnet_on, got.magnet_on);
          check_field("xy_select", want.xy_select, got.xy_select);
          check_field("reverse_dir", want.reverse_dir, got.reverse_dir);
          check_field("phase", want.phase, got.phase);
          check_field("pad", 0, out_tdata[OUT_TDATA_W-1:STATUS_W]);
        end
      end
      if (in_tvalid && in_tready) begin
        tick_sequencer(in_tdata[BUS_W-1:0], in_tdata[BUS_W], in_tdata[BUS_W+1],
                       in_tdata[BUS_W+2], nxt_st);
        status_q.push_back(nxt_st);
      end
    end
    pending = status_q.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
    clear_sequencer();
  end

endmodule

### bench/testbench.sv
// Top of the move sequencer bench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import amseq_pkg::*;

  localparam int DIRECTED_WORDS = 24;
  localparam int RANDOM_WORDS   = 1850;
  // Leave a wide margin for the slowest case with gaps and stalls.
  localparam int CYCLE_LIMIT    = 400000;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_SPARSE
  } rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int unsigned            errors;
  int unsigned            pending;
  int unsigned            cycle_count;
  int unsigned            words_sent;
  int unsigned            burst_left;

  axis_move_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  move_seq_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog that ends the run with an error once the cycle count reaches CYCLE_LIMIT.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver: stall on a pattern whose mode is redrawn at random from span to span,
  // with some stretches of no stall at all.
  initial begin
    rx_mode_t    mode;
    int unsigned span;
    int unsigned phase_ct;
    out_tready = 1'b0;
    phase_ct = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(40, 300);
      repeat (span) begin
        @(negedge clk);
        phase_ct++;
        case (mode)
          RX_FREE:        out_tready = 1'b1;
          RX_COIN:        out_tready = 1'($urandom_range(0, 1));
          RX_EVERY_THIRD: out_tready = (phase_ct % 3) != 0;
          default:        out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Send one tick word; open a new burst after a random gap when the old one runs out.
  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_tick(input logic [BUS_W-1:0] bus, input logic zero_sw,
                           input logic clr_rdy, input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = '0;
    in_tdata[BUS_W-1:0] = bus;
    in_tdata[BUS_W]     = zero_sw;
    in_tdata[BUS_W+1]   = clr_rdy;
    in_tdata[BUS_W+2]   = restart;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Pick a move distance: mostly short, now and then anywhere in range.
  function automatic logic [BUS_W-1:0] pick_distance();
    if ($urandom_range(0, 19) == 0) return BUS_W'($urandom_range(0, 255));
    return BUS_W'($urandom_range(0, 12));
  endfunction

  // One well-formed program: restart to idle, load an instruction, then walk the magnet,
  // recalibrate or move path with random filler, to its end or, for some moves, to a restart.
  task automatic run_program();
    int unsigned       kind;
    int unsigned       steps;
    logic [BUS_W-1:0]  instr;
    logic [BUS_W-1:0]  move_len;
    send_tick(BUS_W'($urandom), 1'($urandom), 1'b1, 1'b1);
    kind  = $urandom_range(0, 5);
    instr = BUS_W'($urandom);
    if (kind == 0) begin
      instr[1] = 1'b1;
    end else if (kind == 1 || kind == 2) begin
      instr[1:0] = 2'b01;
    end else begin
      instr[1:0] = 2'b00;
    end
    send_tick(instr, 1'($urandom), 1'b0, 1'b0);
    send_tick(BUS_W'($urandom), 1'($urandom), 1'b0, 1'b0);
    if (instr[1]) begin
      // Magnet done; ready is set, idle waits.
      repeat ($urandom_range(0, 2)) send_tick(BUS_W'($urandom), 1'($urandom), 1'b0, 1'b0);
    end else if (instr[0]) begin
      // Recalibrate: count down (wrapping) until the home switch closes.
      steps = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 10);
      repeat (steps) send_tick(BUS_W'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
      send_tick(BUS_W'($urandom), 1'b1, 1'b0, 1'b0);
    end else begin
      // Distance wait: clear ready, load the distance, strobe direction, move.
      repeat ($urandom_range(0, 2)) send_tick(BUS_W'($urandom), 1'($urandom), 1'b0, 1'b0);
      send_tick(BUS_W'($urandom), 1'($urandom), 1'b1, 1'b0);
      move_len = pick_distance();
      send_tick(move_len, 1'($urandom), 1'b0, 1'b0);
      send_tick(BUS_W'($urandom), 1'($urandom), 1'b0, 1'b0);
      // Abort some moves part way with a restart.
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, move_len)) begin
          send_tick(BUS_W'($urandom), 1'($urandom), 1'($urandom), 1'b0);
        end
        send_tick(BUS_W'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      end else begin
        repeat (int'(move_len) + 1) begin
          send_tick(BUS_W'($urandom), 1'($urandom), 1'($urandom), 1'b0);
        end
      end
    end
  endtask

  // Noise: fully random words with frequent clears and rare restarts.
  task automatic run_noise();
    repeat ($urandom_range(5, 30)) begin
      send_tick(BUS_W'($urandom), 1'($urandom), $urandom_range(0, 4) < 2,
                $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    int unsigned programs;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    words_sent = 0;
    burst_left = 0;
    programs   = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: magnet path with all flag bits set.
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b1, 1'b1, 1'b0);
    // Recalibrate: count wraps from zero, home switch ends it.
    send_tick(8'h01, 1'b0, 1'b0, 1'b0);
    send_tick(8'hA5, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b1, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b1, 1'b0);
    // Move of zero distance; clear beats set on the instruction tick.
    send_tick(8'h0C, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b1, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b1, 1'b0);
    // Full-range distance, cut short by a restart.
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b1, 1'b1, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b1);
    // Restart while idle, with clear and the home switch also set: no instruction loads.
    send_tick(8'h00, 1'b1, 1'b1, 1'b1);
    drain();

    // Random: mostly well-formed programs, the rest noise.
    while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) run_noise();
      else run_program();
      programs++;
      if (programs % 20 == 0) drain();
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
